[design/pcdfm_pkg.sv]
// shared types and constants for the pulse capture duty and frequency meter
// no dependencies

package pcdfm_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;

    localparam int TICKS_W  = 16;
    localparam int PERIOD_W = 17;
    localparam int CLK_W    = 27;
    localparam int PRESC_W  = 11;
    localparam int DUTY_W   = 7;
    localparam int DENOM_W  = PERIOD_W + PRESC_W;
    localparam int SCALED_W = TICKS_W + 7;

    localparam int MUL_STEPS = PRESC_W;
    localparam int DIV_STEPS = CLK_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CLK_W;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER = 1'd1;

    localparam logic [CLK_W-1:0]   CLOCK_HZ_RST  = 27'd8000000;
    localparam logic [PRESC_W-1:0] PRESCALER_RST = 11'd8;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    typedef enum logic [2:0] {
        ST_ARM,
        ST_HIGH,
        ST_LOW,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } state_t;

endpackage

[design/pulse_capture_duty_freq_meter.sv]
// pulse capture meter: arms on one edge, stores high time, measures on the next
// bit-serial multiply of period by prescaler, then two shared-count restoring dividers
// depends on pcdfm_pkg

// Edge events are taken as capture transfers on the input channel. The low-time
// edge starts the measurement: period times prescaler is formed by a shift-add
// multiplier, then frequency (clock over that product) and duty (high times 100
// over period) come from two restoring dividers that share one bit counter, and the
// result then moves into the output register. A measuring edge's result is held back
// only while an unread result still holds the output register, and the next edge is
// taken once the result has entered the output register, whether or not it has been
// read yet. A zero period sets period_zero and reports zero frequency and duty; a
// zero prescaler gives zero frequency.

module pulse_capture_duty_freq_meter
    import pcdfm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TICKS_W-1:0]    capture_ticks,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TICKS_W-1:0]    high_ticks,
    output logic [TICKS_W-1:0]    low_ticks,
    output logic [PERIOD_W-1:0]   period_ticks,
    output logic [CLK_W-1:0]      frequency_hz,
    output logic [DUTY_W-1:0]     duty_percent,
    output logic                  period_zero
);

    localparam int TICK_W = (COUNTER_WIDTH < TICKS_W) ? COUNTER_WIDTH : TICKS_W;
    localparam logic [TICKS_W-1:0] TICK_MASK = {TICKS_W{1'b1}} >> (TICKS_W - TICK_W);

    // configuration
    logic [CLK_W-1:0]   clock_hz_reg;
    logic [PRESC_W-1:0] prescaler_reg;

    // control
    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    // working datapath
    logic [TICKS_W-1:0]  hi_reg, hi_next;
    logic [TICKS_W-1:0]  lo_reg, lo_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [DENOM_W-1:0]  mcand_reg, mcand_next;
    logic [PRESC_W-1:0]  mplier_reg, mplier_next;
    logic [DENOM_W-1:0]  denom_reg, denom_next;
    logic [CLK_W-1:0]    fnum_reg, fnum_next;
    logic [DENOM_W-1:0]  frem_reg, frem_next;
    logic [CLK_W-1:0]    dnum_reg, dnum_next;
    logic [PERIOD_W-1:0] drem_reg, drem_next;

    // output register
    logic [TICKS_W-1:0]  high_ticks_reg, low_ticks_reg;
    logic [PERIOD_W-1:0] period_ticks_reg;
    logic [CLK_W-1:0]    frequency_hz_reg;
    logic [DUTY_W-1:0]   duty_percent_reg;
    logic                period_zero_reg;
    logic                out_load;

    logic [TICKS_W-1:0]  ticks;
    logic [SCALED_W-1:0] hi_scaled;
    logic [DENOM_W:0]    ftrial;
    logic [DENOM_W:0]    fdiff;
    logic [PERIOD_W:0]   dtrial;
    logic [PERIOD_W:0]   ddiff;

    assign ticks   = capture_ticks & TICK_MASK;

    // high times 100 as 64 + 32 + 4
    assign hi_scaled = {1'b0, hi_reg, 6'b0} + {2'b0, hi_reg, 5'b0} + {5'b0, hi_reg, 2'b0};

    // one restoring step of each divider
    assign ftrial = {frem_reg, fnum_reg[CLK_W-1]};
    assign fdiff  = ftrial - {1'b0, denom_reg};
    assign dtrial = {drem_reg, dnum_reg[CLK_W-1]};
    assign ddiff  = dtrial - {1'b0, period_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg  <= CLOCK_HZ_RST;
            prescaler_reg <= PRESCALER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CLOCK_HZ:  clock_hz_reg  <= cfg_data;
                REG_PRESCALER: prescaler_reg <= cfg_data[PRESC_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ARM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        period_reg <= period_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        denom_reg  <= denom_next;
        fnum_reg   <= fnum_next;
        frem_reg   <= frem_next;
        dnum_reg   <= dnum_next;
        drem_reg   <= drem_next;
        if (out_load)
        begin
            high_ticks_reg   <= hi_reg;
            low_ticks_reg    <= lo_reg;
            period_ticks_reg <= period_reg;
            frequency_hz_reg <= (denom_reg == '0) ? '0 : fnum_reg;
            duty_percent_reg <= (period_reg == '0) ? '0 : dnum_reg[DUTY_W-1:0];
            period_zero_reg  <= (period_reg == '0);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        period_next    = period_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        denom_next     = denom_reg;
        fnum_next      = fnum_reg;
        frem_next      = frem_reg;
        dnum_next      = dnum_reg;
        drem_next      = drem_reg;
        in_ready       = 1'b0;
        out_load       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ARM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_HIGH;
                end
            end
            ST_HIGH:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    hi_next    = ticks;
                    state_next = ST_LOW;
                end
            end
            ST_LOW:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    lo_next     = ticks;
                    period_next = {1'b0, hi_reg} + {1'b0, ticks};
                    mcand_next  = {{(DENOM_W-PERIOD_W){1'b0}}, period_next};
                    mplier_next = prescaler_reg;
                    denom_next  = '0;
                    fnum_next   = clock_hz_reg;
                    frem_next   = '0;
                    dnum_next   = {{(CLK_W-SCALED_W){1'b0}}, hi_scaled};
                    drem_next   = '0;
                    step_next   = STEP_W'(MUL_STEPS);
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    denom_next = denom_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[DENOM_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[PRESC_W-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    step_next  = STEP_W'(DIV_STEPS);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!fdiff[DENOM_W])
                begin
                    frem_next = fdiff[DENOM_W-1:0];
                    fnum_next = {fnum_reg[CLK_W-2:0], 1'b1};
                end
                else
                begin
                    frem_next = ftrial[DENOM_W-1:0];
                    fnum_next = {fnum_reg[CLK_W-2:0], 1'b0};
                end
                if (!ddiff[PERIOD_W])
                begin
                    drem_next = ddiff[PERIOD_W-1:0];
                    dnum_next = {dnum_reg[CLK_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = dtrial[PERIOD_W-1:0];
                    dnum_next = {dnum_reg[CLK_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ARM;
                end
            end
            default:
            begin
                state_next = ST_ARM;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign high_ticks   = high_ticks_reg;
    assign low_ticks    = low_ticks_reg;
    assign period_ticks = period_ticks_reg;
    assign frequency_hz = frequency_hz_reg;
    assign duty_percent = duty_percent_reg;
    assign period_zero  = period_zero_reg;

    // no capture taken while the arithmetic runs
    a_busy_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV || state_reg == ST_LOAD) |-> !in_ready)
        else $error("capture accepted during measurement");

    // a zero period reports zero frequency and duty
    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && period_zero) |-> (frequency_hz == '0 && duty_percent == '0))
        else $error("zero period with nonzero result");

    // duty never exceeds full scale
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= DUTY_MAX))
        else $error("duty above 100");

    // period is the sum of the two phases
    a_period_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (period_ticks == ({1'b0, high_ticks} + {1'b0, low_ticks})))
        else $error("period does not match high plus low");

    // a result enters the output register only after the divide sweep
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> ($past(state_reg) == ST_DIV || $past(state_reg) == ST_LOAD))
        else $error("output load without divide");

endmodule
